### hdl/indexed_array_list_engine_assert.svh
// assertion macros for the list engine, compiled out with NO_ASSERTIONS
`ifndef INDEXED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define IAL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("list engine assertion failed");
// next-cycle implication
`define IAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("list engine assertion failed");
`else
`define IAL_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define IAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/ial_pkg.sv
`default_nettype none

package ial_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int ACTION_W  = 4;
  localparam int POS_W     = 7;
  localparam int WORD_W    = 32;
  localparam int FIELD_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int RD_GROUP  = 8;
  localparam int RD_GROUPS = (CAPACITY + RD_GROUP - 1) / RD_GROUP;

  localparam logic [FIELD_W-1:0] FOUND_NONE = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET     = 4'd0,
    ACT_SET     = 4'd1,
    ACT_PUSH    = 4'd2,
    ACT_POP     = 4'd3,
    ACT_SHIFT   = 4'd4,
    ACT_UNSHIFT = 4'd5,
    ACT_INSERT  = 4'd6,
    ACT_REMOVE  = 4'd7,
    ACT_FIND    = 4'd8,
    ACT_COUNT   = 4'd9,
    ACT_CLEAR   = 4'd10
  } ial_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } ial_status_e;

  // what the row of cells does in one cycle
  typedef enum logic [1:0] {
    ROW_IDLE  = 2'd0,
    ROW_WRITE = 2'd1,
    ROW_OPEN  = 2'd2,
    ROW_CLOSE = 2'd3
  } ial_row_op_e;

  typedef struct packed {
    ial_row_op_e              op;
    logic [IDX_W-1:0]         at;
    logic signed [WORD_W-1:0] word;
  } ial_row_t;

endpackage

`default_nettype wire

### hdl/ial_req_if.sv
`default_nettype none

interface ial_req_if;
  logic                             valid;
  logic                             ready;
  logic [ial_pkg::ACTION_W-1:0]     action;
  logic [ial_pkg::POS_W-1:0]        position;
  logic signed [ial_pkg::WORD_W-1:0] word_in;

  modport source (output valid, action, position, word_in, input ready);
  modport sink (input valid, action, position, word_in, output ready);
endinterface

`default_nettype wire

### hdl/ial_rsp_if.sv
`default_nettype none

interface ial_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ial_pkg::WORD_W-1:0]  word_out;
  logic signed [ial_pkg::FIELD_W-1:0] found_at;
  logic [ial_pkg::FIELD_W-1:0]        match_total;
  logic [ial_pkg::FIELD_W-1:0]        length_now;
  logic [ial_pkg::STATUS_W-1:0]       status;

  modport source (output valid, word_out, found_at, match_total, length_now, status,
                  input ready);
  modport sink (input valid, word_out, found_at, match_total, length_now, status,
                output ready);
endinterface

`default_nettype wire

### hdl/ial_cell.sv
`default_nettype none

module ial_cell (
  input  wire logic                        clk_i,
  input  wire logic [ial_pkg::IDX_W-1:0]   idx_i,
  input  wire ial_pkg::ial_row_t           row_i,
  input  wire logic [ial_pkg::WORD_W-1:0]  prev_i,
  input  wire logic [ial_pkg::WORD_W-1:0]  next_i,
  output logic      [ial_pkg::WORD_W-1:0]  data_o,
  output logic                             match_o
);

  logic [ial_pkg::WORD_W-1:0] data_q;
  logic [ial_pkg::WORD_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (row_i.op)
      ial_pkg::ROW_IDLE: begin
        data_d = data_q;
      end
      ial_pkg::ROW_WRITE: begin
        if (idx_i == row_i.at) data_d = row_i.word;
      end
      // make room: cells above the point take the word from below
      ial_pkg::ROW_OPEN: begin
        if (idx_i == row_i.at) begin
          data_d = row_i.word;
        end else if (idx_i > row_i.at) begin
          data_d = prev_i;
        end
      end
      // close the gap: cells from the point up take the word from above
      ial_pkg::ROW_CLOSE: begin
        if (idx_i >= row_i.at) data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == row_i.word);

endmodule

`default_nettype wire

### hdl/indexed_array_list_engine.sv
// Bounded ordered list of up to 64 signed 32-bit words, kept in a row of cells where
// cell i holds element i and count_q says how many are live. Each request beat carries
// one action; each yields exactly one response beat. Set, push, shift, unshift, insert
// and remove update the row in the cycle the request is accepted (inserts and removes
// slide the row by one place in that same cycle); get and pop read a word, and pop and
// clear change the live count. For these actions the result is loaded into the output
// register from the final state once that register is free. Reads gather the addressed
// word through a registered two-level select. Find and count compare the key against all
// cells at acceptance, latch the match flags and then walk them one cell per cycle,
// stopping at the first match (find) or when no flags remain. One item is in flight at
// a time; a new request is taken as soon as the engine is back in idle, even while the
// previous response still waits in the output register. A response that is not drained
// holds the engine in its final state until the output register frees up. Stored words
// are not cleared by reset; only the live count is.
`default_nettype none
`include "indexed_array_list_engine_assert.svh"

module indexed_array_list_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ial_req_if.sink   req_i,
  ial_rsp_if.source rsp_o
);

  localparam int CAP     = ial_pkg::CAPACITY;
  localparam int IDX_W   = ial_pkg::IDX_W;
  localparam int CNT_W   = ial_pkg::FIELD_W;
  localparam int WORD_W  = ial_pkg::WORD_W;
  localparam int GRP     = ial_pkg::RD_GROUP;
  localparam int NGRP    = ial_pkg::RD_GROUPS;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_FIN  = 2'd1,
    S_SCAN = 2'd2
  } state_e;

  state_e state_q;

  // live element count
  logic [CNT_W-1:0] count_q;

  // per-item registers
  ial_pkg::ial_status_e st_q;
  logic                 rd_en_q;
  logic [WORD_W-1:0]    grp_q [NGRP];
  logic [CAP-1:0]       scan_q;
  logic                 find_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     tot_q;

  // output register
  logic                 out_valid_q;
  logic [WORD_W-1:0]    out_word_q;
  logic [CNT_W-1:0]     out_found_q;
  logic [CNT_W-1:0]     out_total_q;
  logic [CNT_W-1:0]     out_len_q;
  logic [ial_pkg::STATUS_W-1:0] out_status_q;

  logic req_fire;
  logic out_free;
  logic scan_done;
  logic out_load;

  // decode of the request against the current count
  ial_pkg::ial_row_op_e dec_op;
  logic [IDX_W-1:0]     dec_at;
  ial_pkg::ial_status_e dec_status;
  logic [CNT_W-1:0]     dec_count;
  logic                 dec_rd_en;
  logic [IDX_W-1:0]     dec_rd_at;
  logic                 dec_scan;
  logic                 cnt_full;
  logic [CNT_W-1:0]     cnt_dec;
  logic [CNT_W-1:0]     cnt_inc;

  ial_pkg::ial_row_t    row;
  logic [WORD_W-1:0]    cell_data  [CAP];
  logic [CAP-1:0]       cell_match;
  logic [CAP-1:0]       match_vec;
  logic [CAP-1:0]       rd_sel;
  logic [WORD_W-1:0]    grp_d      [NGRP];
  logic [WORD_W-1:0]    grp_or;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  // a finished result may be written when the output slot is empty or being drained
  assign out_free    = !out_valid_q || rsp_o.ready;
  // the walk ends when no flags remain or find sits on its first match
  assign scan_done   = (scan_q == '0) || (find_q && scan_q[0]);
  assign out_load    = out_free && ((state_q == S_FIN) || ((state_q == S_SCAN) && scan_done));

  assign cnt_full = (count_q >= CNT_W'(CAP));
  assign cnt_dec  = count_q - CNT_W'(1);
  assign cnt_inc  = count_q + CNT_W'(1);

  always_comb begin
    dec_op     = ial_pkg::ROW_IDLE;
    dec_at     = req_i.position[IDX_W-1:0];
    dec_status = ial_pkg::ST_DONE;
    dec_count  = count_q;
    dec_rd_en  = 1'b0;
    dec_rd_at  = req_i.position[IDX_W-1:0];
    dec_scan   = 1'b0;
    unique case (req_i.action)
      ial_pkg::ACT_GET: begin
        if (CNT_W'(req_i.position) < count_q) dec_rd_en = 1'b1;
        else dec_status = ial_pkg::ST_IGNORED;
      end
      ial_pkg::ACT_SET: begin
        if (CNT_W'(req_i.position) < count_q) dec_op = ial_pkg::ROW_WRITE;
        else dec_status = ial_pkg::ST_IGNORED;
      end
      ial_pkg::ACT_PUSH: begin
        if (cnt_full) begin
          dec_status = ial_pkg::ST_FULL;
        end else begin
          dec_op    = ial_pkg::ROW_WRITE;
          dec_at    = count_q[IDX_W-1:0];
          dec_count = cnt_inc;
        end
      end
      ial_pkg::ACT_POP: begin
        if (count_q == '0) begin
          dec_status = ial_pkg::ST_IGNORED;
        end else begin
          dec_rd_en = 1'b1;
          dec_rd_at = cnt_dec[IDX_W-1:0];
          dec_count = cnt_dec;
        end
      end
      ial_pkg::ACT_SHIFT: begin
        if (count_q == '0) begin
          dec_status = ial_pkg::ST_IGNORED;
        end else begin
          dec_rd_en = 1'b1;
          dec_rd_at = '0;
          dec_op    = ial_pkg::ROW_CLOSE;
          dec_at    = '0;
          dec_count = cnt_dec;
        end
      end
      ial_pkg::ACT_UNSHIFT: begin
        if (cnt_full) begin
          dec_status = ial_pkg::ST_FULL;
        end else begin
          dec_op    = ial_pkg::ROW_OPEN;
          dec_at    = '0;
          dec_count = cnt_inc;
        end
      end
      // index check comes before the full check
      ial_pkg::ACT_INSERT: begin
        if (CNT_W'(req_i.position) > count_q) begin
          dec_status = ial_pkg::ST_IGNORED;
        end else if (cnt_full) begin
          dec_status = ial_pkg::ST_FULL;
        end else begin
          dec_op    = ial_pkg::ROW_OPEN;
          dec_count = cnt_inc;
        end
      end
      ial_pkg::ACT_REMOVE: begin
        if (CNT_W'(req_i.position) < count_q) begin
          dec_op    = ial_pkg::ROW_CLOSE;
          dec_count = cnt_dec;
        end else begin
          dec_status = ial_pkg::ST_IGNORED;
        end
      end
      ial_pkg::ACT_FIND, ial_pkg::ACT_COUNT: begin
        dec_scan = 1'b1;
      end
      ial_pkg::ACT_CLEAR: begin
        dec_count = '0;
      end
      default: begin
        dec_status = ial_pkg::ST_IGNORED;
      end
    endcase
  end

  // row command only moves the cells on an accepted beat
  assign row.op   = req_fire ? dec_op : ial_pkg::ROW_IDLE;
  assign row.at   = dec_at;
  assign row.word = req_i.word_in;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] next;

    if (i == 0) begin : g_first
      assign prev = row.word;
    end else begin : g_mid_lo
      assign prev = cell_data[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_mid_hi
      assign next = cell_data[i+1];
    end

    ial_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .row_i   (row),
      .prev_i  (prev),
      .next_i  (next),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );

    // only live cells take part in a search
    assign match_vec[i] = cell_match[i] && (CNT_W'(i) < count_q);
    assign rd_sel[i]    = dec_rd_en && (dec_rd_at == IDX_W'(i));
  end

  // first level of the read select, registered per group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAP) begin
          if (rd_sel[g * GRP + k]) grp_d[g] = grp_d[g] | cell_data[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    grp_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_or = grp_or | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      st_q         <= ial_pkg::ST_DONE;
      rd_en_q      <= 1'b0;
      grp_q        <= '{default: '0};
      scan_q       <= '0;
      find_q       <= 1'b0;
      idx_q        <= '0;
      tot_q        <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
      out_found_q  <= ial_pkg::FOUND_NONE;
      out_total_q  <= '0;
      out_len_q    <= '0;
      out_status_q <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            count_q <= dec_count;
            st_q    <= dec_status;
            rd_en_q <= dec_rd_en;
            grp_q   <= grp_d;
            scan_q  <= match_vec;
            find_q  <= (req_i.action == ial_pkg::ACT_FIND);
            idx_q   <= '0;
            tot_q   <= '0;
            state_q <= dec_scan ? S_SCAN : S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_word_q   <= rd_en_q ? grp_or : '0;
            out_found_q  <= ial_pkg::FOUND_NONE;
            out_total_q  <= '0;
            out_len_q    <= count_q;
            out_status_q <= st_q;
            state_q      <= S_IDLE;
          end
        end
        // walk the match flags one cell per cycle
        S_SCAN: begin
          if (scan_done) begin
            if (out_free) begin
              out_word_q   <= '0;
              out_found_q  <= (find_q && scan_q[0]) ? CNT_W'(idx_q) : ial_pkg::FOUND_NONE;
              out_total_q  <= find_q ? '0 : tot_q;
              out_len_q    <= count_q;
              out_status_q <= ial_pkg::ST_DONE;
              state_q      <= S_IDLE;
            end
          end else begin
            scan_q <= scan_q >> 1;
            idx_q  <= idx_q + IDX_W'(1);
            if (scan_q[0]) tot_q <= tot_q + CNT_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.word_out    = out_word_q;
  assign rsp_o.found_at    = out_found_q;
  assign rsp_o.match_total = out_total_q;
  assign rsp_o.length_now  = out_len_q;
  assign rsp_o.status      = out_status_q;

  `IAL_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAP))
  `IAL_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, req_fire && (req_i.action == ial_pkg::ACT_PUSH) && !cnt_full, count_q == $past(count_q) + CNT_W'(1))
  `IAL_ASSERT_NEXT(a_search_enters_scan, clk_i, rst_ni, req_fire && ((req_i.action == ial_pkg::ACT_FIND) || (req_i.action == ial_pkg::ACT_COUNT)), (state_q == S_SCAN) && (count_q == $past(count_q)))
  `IAL_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, req_fire && (req_i.action == ial_pkg::ACT_CLEAR), count_q == '0)
  `IAL_ASSERT_IMPL(a_tally_bound, clk_i, rst_ni, state_q == S_SCAN, tot_q <= count_q)

endmodule

`default_nettype wire
